@@ design/todcs_pkg.sv @@
// Shared types and constants for the time-of-day clock with stopwatch.
// Holds the command codes, counter control struct and field limits.
// No dependencies.
`timescale 1ns / 1ps

package todcs_pkg;

    localparam int TICKS_PER_SECOND_DEF = 10;

    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;
    localparam int SUB_W     = 4;
    localparam int COMMAND_W = 3;

    localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
    localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);

    typedef enum logic [COMMAND_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_SET_TIME   = 3'd1,
        CMD_READ_CLOCK = 3'd2,
        CMD_READ_WATCH = 3'd3,
        CMD_SET_RUN    = 3'd4
    } command_t;

    typedef struct packed {
        logic advance;
        logic load;
        logic clear;
    } cnt_ctrl_t;

endpackage

@@ design/time_of_day_clock_with_stopwatch_unit.sv @@
// Top level of the time-of-day clock with stopwatch: stream ports, input
// and result registers, command decode. Depends on todcs_pkg, todcs_counter.
`timescale 1ns / 1ps

// Takes one command beat per cycle while s_axis_tready is high and returns
// at most one result beat per command, in order. A beat is held in the
// input register and is then executed as its result is written to the
// output register, so m_axis_tvalid rises once the beat has passed through
// both registers in turn. Throughput is one beat per cycle while
// m_axis_tready stays high. Under backpressure the unit holds at most two
// beats, one in each register, and every command, including those without a
// result, waits in the input register until the output register is free.
// Both counts are kept as hours, minutes,
// seconds and sub-second ticks, so reads need no conversion. Tick commands
// always advance the clock; while the stopwatch runs they also advance it
// and report its new value. Set-time clamps out-of-range fields. Set-run
// with run high clears and starts the stopwatch, with run low stops it.
// Commands 5 to 7 are consumed with no effect.
module time_of_day_clock_with_stopwatch_unit #(
    parameter int TICKS_PER_SECOND = todcs_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // set_hour[4:0], set_minute[10:5], set_second[16:11], set_ticks[20:17], run[21]
    input  logic [23:0]                       s_axis_tdata,
    // command[2:0]
    input  logic [todcs_pkg::COMMAND_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // hour[4:0], minute[10:5], second[16:11], sub_ticks[20:17], running[21]
    output logic [23:0]                       m_axis_tdata,
    // from_stopwatch[0]
    output logic                              m_axis_tuser
);
    import todcs_pkg::*;

    localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int CMP_W  = (TICK_W > SUB_W) ? TICK_W : SUB_W;
    localparam logic [CMP_W-1:0] TICK_TOP = CMP_W'(TICKS_PER_SECOND - 1);

    // input register
    logic                 in_vld_reg;
    logic [COMMAND_W-1:0] in_cmd_reg;
    logic [21:0]          in_data_reg;
    // output register
    logic                 m_vld_reg;
    logic [21:0]          m_data_reg;
    logic                 m_user_reg;
    logic                 running_reg;
    logic                 running_next;

    logic out_ready;
    logic proceed;

    logic [HOUR_W-1:0]   set_hour;
    logic [MINUTE_W-1:0] set_minute;
    logic [SECOND_W-1:0] set_second;
    logic [SUB_W-1:0]    set_ticks;
    logic                set_run;

    logic [HOUR_W-1:0]   ld_hour;
    logic [MINUTE_W-1:0] ld_minute;
    logic [SECOND_W-1:0] ld_second;
    logic [CMP_W-1:0]    set_ticks_ext;
    logic [CMP_W-1:0]    ld_ticks_ext;
    logic [TICK_W-1:0]   ld_ticks;

    cnt_ctrl_t clock_ctrl;
    cnt_ctrl_t watch_ctrl;

    logic [HOUR_W-1:0]   clk_hour,   clk_adv_hour,   wch_hour,   wch_adv_hour;
    logic [MINUTE_W-1:0] clk_minute, clk_adv_minute, wch_minute, wch_adv_minute;
    logic [SECOND_W-1:0] clk_second, clk_adv_second, wch_second, wch_adv_second;
    logic [TICK_W-1:0]   clk_ticks,  clk_adv_ticks,  wch_ticks,  wch_adv_ticks;

    logic                res_valid;
    logic                res_from_watch;
    logic [HOUR_W-1:0]   res_hour;
    logic [MINUTE_W-1:0] res_minute;
    logic [SECOND_W-1:0] res_second;
    logic [TICK_W-1:0]   res_ticks;
    logic [CMP_W-1:0]    res_ticks_ext;

    assign out_ready     = !m_vld_reg || m_axis_tready;
    assign proceed       = in_vld_reg && out_ready;
    assign s_axis_tready = !in_vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata[21:0];
        end
    end

    assign set_hour   = in_data_reg[4:0];
    assign set_minute = in_data_reg[10:5];
    assign set_second = in_data_reg[16:11];
    assign set_ticks  = in_data_reg[20:17];
    assign set_run    = in_data_reg[21];

    // clamp set-time fields
    always_comb begin
        ld_hour       = (set_hour > HOUR_MAX) ? HOUR_MAX : set_hour;
        ld_minute     = (set_minute > MINUTE_MAX) ? MINUTE_MAX : set_minute;
        ld_second     = (set_second > SECOND_MAX) ? SECOND_MAX : set_second;
        set_ticks_ext = CMP_W'(set_ticks);
        ld_ticks_ext  = (set_ticks_ext > TICK_TOP) ? TICK_TOP : set_ticks_ext;
        ld_ticks      = ld_ticks_ext[TICK_W-1:0];
    end

    always_comb begin
        clock_ctrl     = '0;
        watch_ctrl     = '0;
        running_next   = running_reg;
        res_valid      = 1'b0;
        res_from_watch = 1'b0;
        res_hour       = clk_hour;
        res_minute     = clk_minute;
        res_second     = clk_second;
        res_ticks      = clk_ticks;
        if (proceed) begin
            unique case (in_cmd_reg)
                CMD_TICK: begin
                    clock_ctrl.advance = 1'b1;
                    if (running_reg) begin
                        watch_ctrl.advance = 1'b1;
                        res_valid          = 1'b1;
                        res_from_watch     = 1'b1;
                        res_hour           = wch_adv_hour;
                        res_minute         = wch_adv_minute;
                        res_second         = wch_adv_second;
                        res_ticks          = wch_adv_ticks;
                    end
                end
                CMD_SET_TIME: begin
                    clock_ctrl.load = 1'b1;
                end
                CMD_READ_CLOCK: begin
                    res_valid = 1'b1;
                end
                CMD_READ_WATCH: begin
                    res_valid      = 1'b1;
                    res_from_watch = 1'b1;
                    res_hour       = wch_hour;
                    res_minute     = wch_minute;
                    res_second     = wch_second;
                    res_ticks      = wch_ticks;
                end
                CMD_SET_RUN: begin
                    running_next     = set_run;
                    watch_ctrl.clear = set_run;
                end
                default: begin
                end
            endcase
        end
        res_ticks_ext = CMP_W'(res_ticks);
    end

    todcs_counter #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TICK_W           (TICK_W)
    ) u_clock (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (clock_ctrl),
        .load_hour   (ld_hour),
        .load_minute (ld_minute),
        .load_second (ld_second),
        .load_ticks  (ld_ticks),
        .cur_hour    (clk_hour),
        .cur_minute  (clk_minute),
        .cur_second  (clk_second),
        .cur_ticks   (clk_ticks),
        .adv_hour    (clk_adv_hour),
        .adv_minute  (clk_adv_minute),
        .adv_second  (clk_adv_second),
        .adv_ticks   (clk_adv_ticks)
    );

    todcs_counter #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TICK_W           (TICK_W)
    ) u_watch (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (watch_ctrl),
        .load_hour   (ld_hour),
        .load_minute (ld_minute),
        .load_second (ld_second),
        .load_ticks  (ld_ticks),
        .cur_hour    (wch_hour),
        .cur_minute  (wch_minute),
        .cur_second  (wch_second),
        .cur_ticks   (wch_ticks),
        .adv_hour    (wch_adv_hour),
        .adv_minute  (wch_adv_minute),
        .adv_second  (wch_adv_second),
        .adv_ticks   (wch_adv_ticks)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg   <= 1'b0;
            running_reg <= 1'b0;
        end else begin
            running_reg <= running_next;
            if (res_valid) begin
                m_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            m_data_reg <= {running_next, res_ticks_ext[SUB_W-1:0], res_second,
                           res_minute, res_hour};
            m_user_reg <= res_from_watch;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {2'b00, m_data_reg};
    assign m_axis_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_fields_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_data_reg[4:0] <= HOUR_MAX) &&
                          (m_data_reg[10:5] <= MINUTE_MAX) &&
                          (m_data_reg[16:11] <= SECOND_MAX))
        else $error("result field out of range");

    a_no_result_for_set: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && !m_vld_reg &&
        (in_cmd_reg == CMD_SET_TIME || in_cmd_reg == CMD_SET_RUN)
        |=> !m_axis_tvalid)
        else $error("set command produced a result beat");

    a_watch_holds_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && in_cmd_reg == CMD_TICK && !running_reg
        |=> wch_ticks == $past(wch_ticks) && wch_second == $past(wch_second))
        else $error("stopwatch advanced while stopped");

    a_no_drop_under_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_ready |=> in_vld_reg && in_cmd_reg == $past(in_cmd_reg))
        else $error("pending beat lost while output stalled");
`endif

endmodule

@@ design/todcs_counter.sv @@
// Mixed-radix hours/minutes/seconds/ticks counter that wraps after one day.
// Depends on todcs_pkg for field widths, limits and the control struct.
`timescale 1ns / 1ps

module todcs_counter #(
    parameter int TICKS_PER_SECOND = todcs_pkg::TICKS_PER_SECOND_DEF,
    parameter int TICK_W           = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  todcs_pkg::cnt_ctrl_t          ctrl,
    input  logic [todcs_pkg::HOUR_W-1:0]   load_hour,
    input  logic [todcs_pkg::MINUTE_W-1:0] load_minute,
    input  logic [todcs_pkg::SECOND_W-1:0] load_second,
    input  logic [TICK_W-1:0]              load_ticks,
    output logic [todcs_pkg::HOUR_W-1:0]   cur_hour,
    output logic [todcs_pkg::MINUTE_W-1:0] cur_minute,
    output logic [todcs_pkg::SECOND_W-1:0] cur_second,
    output logic [TICK_W-1:0]              cur_ticks,
    output logic [todcs_pkg::HOUR_W-1:0]   adv_hour,
    output logic [todcs_pkg::MINUTE_W-1:0] adv_minute,
    output logic [todcs_pkg::SECOND_W-1:0] adv_second,
    output logic [TICK_W-1:0]              adv_ticks
);
    import todcs_pkg::*;

    localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'(TICKS_PER_SECOND - 1);

    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    logic [SECOND_W-1:0] second_reg;
    logic [TICK_W-1:0]   ticks_reg;
    logic                tick_wrap;
    logic                second_wrap;
    logic                minute_wrap;

    always_comb begin
        tick_wrap   = (ticks_reg == TICK_MAX);
        second_wrap = tick_wrap && (second_reg == SECOND_MAX);
        minute_wrap = second_wrap && (minute_reg == MINUTE_MAX);

        adv_ticks  = tick_wrap ? '0 : ticks_reg + TICK_W'(1);
        adv_second = second_reg;
        adv_minute = minute_reg;
        adv_hour   = hour_reg;
        if (tick_wrap) begin
            adv_second = (second_reg == SECOND_MAX) ? '0 : second_reg + SECOND_W'(1);
        end
        if (second_wrap) begin
            adv_minute = (minute_reg == MINUTE_MAX) ? '0 : minute_reg + MINUTE_W'(1);
        end
        if (minute_wrap) begin
            adv_hour = (hour_reg == HOUR_MAX) ? '0 : hour_reg + HOUR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            ticks_reg  <= '0;
        end else if (ctrl.load) begin
            hour_reg   <= load_hour;
            minute_reg <= load_minute;
            second_reg <= load_second;
            ticks_reg  <= load_ticks;
        end else if (ctrl.advance) begin
            hour_reg   <= adv_hour;
            minute_reg <= adv_minute;
            second_reg <= adv_second;
            ticks_reg  <= adv_ticks;
        end
    end

    assign cur_hour   = hour_reg;
    assign cur_minute = minute_reg;
    assign cur_second = second_reg;
    assign cur_ticks  = ticks_reg;

endmodule
